@@ design/bit_packed_element_packer_assert.svh @@
// Assertion macros for the bit packed element packer
`ifndef BIT_PACKED_ELEMENT_PACKER_ASSERT_SVH
`define BIT_PACKED_ELEMENT_PACKER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BPEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpep assertion failed");

// next-cycle implication
`define BPEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpep assertion failed");

`endif

@@ design/bpep_pkg.sv @@
// Package: constants and types shared by the bit packed element packer
package bpep_pkg;

    localparam int VALUE_W          = 64;
    localparam int CFG_W            = 7;
    localparam int BYTE_BITS        = 8;
    localparam int ELEMENT_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd8;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic             last;
    } t_elem_ctl;

endpackage

@@ design/bpep_ifs.sv @@
// Interfaces: element input, byte output and configuration channels
interface bpep_elem_if;
    logic                            valid;
    logic                            ready;
    logic [bpep_pkg::VALUE_W-1:0]    element_value;
    logic                            last_element;

    modport source (output valid, element_value, last_element, input ready);
    modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface bpep_byte_if;
    logic                            valid;
    logic                            ready;
    logic [bpep_pkg::BYTE_BITS-1:0]  packed_byte;
    logic                            last_byte;

    modport source (output valid, packed_byte, last_byte, input ready);
    modport sink   (input valid, packed_byte, last_byte, output ready);
endinterface

interface bpep_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bpep_pkg::CFG_W-1:0]      element_width;

    modport source (output valid, element_width, input ready);
    modport sink   (input valid, element_width, output ready);
endinterface

@@ design/bpep_fifo.sv @@
// Small register queue between the front and back parts
module bpep_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bpep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ design/bpep_front.sv @@
// Front part: width register, item accept, width clamp and value masking
module bpep_front #(
    parameter int ELEMENT_BITS = bpep_pkg::ELEMENT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    bpep_cfg_if.sink                 i_cfg,
    bpep_elem_if.sink                i_elem,
    input  logic                     i_full,
    output logic                     o_push,
    output logic [ELEMENT_BITS-1:0]  o_value,
    output bpep_pkg::t_elem_ctl      o_ctl
);
    logic [bpep_pkg::CFG_W-1:0] r_width;
    logic [bpep_pkg::CFG_W-1:0] w_eff;
    logic [ELEMENT_BITS-1:0]    w_mask;

    assign i_cfg.ready  = 1'b1;
    assign i_elem.ready = !i_full;
    assign o_push       = i_elem.valid && !i_full;

    // widths past the element size saturate
    assign w_eff   = (r_width > bpep_pkg::CFG_W'(ELEMENT_BITS))
                   ? bpep_pkg::CFG_W'(ELEMENT_BITS) : r_width;
    assign w_mask  = ~({ELEMENT_BITS{1'b1}} << w_eff);
    assign o_value = i_elem.element_value[ELEMENT_BITS-1:0] & w_mask;
    assign o_ctl.width = w_eff;
    assign o_ctl.last  = i_elem.last_element;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= bpep_pkg::WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_width <= i_cfg.element_width;
        end
    end

endmodule

@@ design/bpep_back.sv @@
// Back part: bit accumulator, byte emission and output register
module bpep_back #(
    parameter int ELEMENT_BITS = bpep_pkg::ELEMENT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  logic [ELEMENT_BITS-1:0]  i_value,
    input  bpep_pkg::t_elem_ctl      i_ctl,
    output logic                     o_pop,
    output logic                     o_pending,
    bpep_byte_if.source              o_byte
);
    localparam int BB    = bpep_pkg::BYTE_BITS;
    localparam int ACC_W = ELEMENT_BITS + BB - 1;
    localparam int CNT_W = $clog2(ELEMENT_BITS + BB);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_valid, n_valid;
    logic [BB-1:0]    r_byte, n_byte;
    logic             r_lbyte, n_lbyte;
    logic             w_full_byte;
    logic             w_out_free;
    logic             w_emit;

    assign w_full_byte = (r_cnt >= CNT_W'(BB));
    assign o_pending   = w_full_byte || (r_last && (r_cnt != '0));
    assign w_out_free  = !r_valid || o_byte.ready;
    assign w_emit      = o_pending && w_out_free;
    assign o_pop       = !o_pending && !i_empty;

    assign o_byte.valid       = r_valid;
    assign o_byte.packed_byte = r_byte;
    assign o_byte.last_byte   = r_lbyte;

    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_valid = r_valid && !o_byte.ready;
        n_byte  = r_byte;
        n_lbyte = r_lbyte;
        if (w_emit) begin
            // bits above the count are zero, so a partial byte comes out padded
            n_valid = 1'b1;
            n_byte  = r_acc[BB-1:0];
            n_lbyte = r_last && (r_cnt <= CNT_W'(BB));
            n_acc   = r_acc >> BB;
            n_cnt   = w_full_byte ? r_cnt - CNT_W'(BB) : '0;
        end else if (o_pop) begin
            n_acc  = r_acc | ({{(BB-1){1'b0}}, i_value} << r_cnt[2:0]);
            n_cnt  = r_cnt + CNT_W'(i_ctl.width);
            n_last = i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_lbyte <= n_lbyte;
    end

endmodule

@@ design/bit_packed_element_packer.sv @@
// Top level: LSB-first bit packer of elements into a byte stream
// An element is accepted in any cycle while the element queue has room, so
// elements stream in back to back. The back end loads an element into its
// bit accumulator and then emits one output byte per cycle while the byte
// output is ready, plus a flushed partial byte on the last element of a run;
// it takes no new element while bytes are pending. Widths above ELEMENT_BITS
// are clamped to it; a width of zero packs nothing.
`include "bit_packed_element_packer_assert.svh"

module bit_packed_element_packer #(
    parameter int ELEMENT_BITS = bpep_pkg::ELEMENT_BITS_DEF,
    parameter int QUEUE_DEPTH  = bpep_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpep_cfg_if.sink    i_cfg,
    bpep_elem_if.sink   i_elem,
    bpep_byte_if.source o_byte
);
    localparam int Q_W = $bits(bpep_pkg::t_elem_ctl) + ELEMENT_BITS;

    logic                    w_push;
    logic                    w_pop;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_pending;
    logic [ELEMENT_BITS-1:0] w_in_value;
    logic [ELEMENT_BITS-1:0] w_out_value;
    bpep_pkg::t_elem_ctl     w_in_ctl;
    bpep_pkg::t_elem_ctl     w_out_ctl;

    bpep_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_elem  (i_elem),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_value (w_in_value),
        .o_ctl   (w_in_ctl)
    );

    bpep_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_in_ctl, w_in_value}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  ({w_out_ctl, w_out_value}),
        .o_empty (w_empty)
    );

    bpep_back #(.ELEMENT_BITS(ELEMENT_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_value   (w_out_value),
        .i_ctl     (w_out_ctl),
        .o_pop     (w_pop),
        .o_pending (w_pending),
        .o_byte    (o_byte)
    );

    `BPEP_ASSERT_NOW(a_push_not_full, w_push, !w_full)
    `BPEP_ASSERT_NOW(a_pop_not_empty, w_pop, !w_empty)
    `BPEP_ASSERT_NOW(a_pop_only_idle, w_pop, !w_pending)
    `BPEP_ASSERT_NEXT(a_pop_frees_slot, w_pop && !w_push && w_full, !w_full)

endmodule
